/* src/speed_dial_address_memory_unit_macros.svh */
// Assertion macros for the files that check their own logic.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef SPEED_DIAL_ADDRESS_MEMORY_UNIT_MACROS_SVH
`define SPEED_DIAL_ADDRESS_MEMORY_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDAM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdam: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SDAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdam: next-cycle check failed");

`endif

/* src/sdam_pkg.sv */
package sdam_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 63;
  localparam int DECIMAL_BASE          = 10;

  localparam int REQ_W    = 3;
  localparam int DIGIT_W  = 4;
  localparam int STATUS_W = 4;
  localparam int ADDR_W   = 32;
  localparam int SHOW_W   = 6;
  localparam int ERR_W    = 2;

  localparam logic [REQ_W-1:0] REQ_START_SAVE   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START_RECALL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR        = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DIGIT        = 3'd3;
  localparam logic [REQ_W-1:0] REQ_BACKSPACE    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_ENTER_SAVE   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_ENTER_RECALL = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OFFHOOK   = 4'd0;
  localparam logic [STATUS_W-1:0] ST_SAVING    = 4'd1;
  localparam logic [STATUS_W-1:0] ST_RECALLING = 4'd2;
  localparam logic [STATUS_W-1:0] ST_RECALLED  = 4'd3;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_LOC   = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [DIGIT_W-1:0]  digit;
    logic [STATUS_W-1:0] caller_status;
    logic [ADDR_W-1:0]   calling_ip;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] new_status;
    logic [SHOW_W-1:0]   shown_location;
    logic                show_location;
    logic [ADDR_W-1:0]   address_value;
    logic                show_address;
    logic                load_address;
    logic [ERR_W-1:0]    error_code;
  } rsp_item_t;

endpackage

/* src/sdam_req_if.sv */
interface sdam_req_if;
  logic                          valid;
  logic                          ready;
  logic [sdam_pkg::REQ_W-1:0]    req_type;
  logic [sdam_pkg::DIGIT_W-1:0]  digit;
  logic [sdam_pkg::STATUS_W-1:0] caller_status;
  logic [sdam_pkg::ADDR_W-1:0]   calling_ip;

  modport source (output valid, req_type, digit, caller_status, calling_ip, input ready);
  modport sink (input valid, req_type, digit, caller_status, calling_ip, output ready);
endinterface

/* src/sdam_rsp_if.sv */
interface sdam_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sdam_pkg::STATUS_W-1:0] new_status;
  logic [sdam_pkg::SHOW_W-1:0]   shown_location;
  logic                          show_location;
  logic [sdam_pkg::ADDR_W-1:0]   address_value;
  logic                          show_address;
  logic                          load_address;
  logic [sdam_pkg::ERR_W-1:0]    error_code;

  modport source (
    output valid, new_status, shown_location, show_location, address_value,
           show_address, load_address, error_code,
    input  ready
  );
  modport sink (
    input  valid, new_status, shown_location, show_location, address_value,
           show_address, load_address, error_code,
    output ready
  );
endinterface

/* src/sdam_table.sv */
module sdam_table #(
  parameter int TABLE_ENTRIES = sdam_pkg::TABLE_ENTRIES_DEFAULT,
  localparam int LOC_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [LOC_W-1:0]            wr_addr,
  input  logic [sdam_pkg::ADDR_W-1:0] wr_data,
  input  logic [LOC_W-1:0]            rd_addr,
  output logic [sdam_pkg::ADDR_W-1:0] rd_data,
  output logic                        busy
);
  import sdam_pkg::*;

  localparam int DEPTH = TABLE_ENTRIES + 1;
  localparam logic [LOC_W-1:0] LAST_IDX = LOC_W'(TABLE_ENTRIES);

  logic [ADDR_W-1:0] mem [DEPTH];
  logic [LOC_W-1:0]  clr_idx;
  logic              we;
  logic [LOC_W-1:0]  waddr;
  logic [ADDR_W-1:0] wdata;

  // After reset every entry is swept to zero, one a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      if (clr_idx == LAST_IDX) begin
        busy <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_comb begin
    we    = busy | wr_en;
    waddr = busy ? clr_idx : wr_addr;
    wdata = busy ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A write to the address being read is passed straight through.
  always_ff @(posedge clk) begin
    if (we && (waddr == rd_addr)) begin
      rd_data <= wdata;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/sdam_keypad.sv */
module sdam_keypad #(
  parameter int TABLE_ENTRIES = sdam_pkg::TABLE_ENTRIES_DEFAULT,
  localparam int LOC_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  sdam_pkg::req_item_t         item,
  input  logic [sdam_pkg::ADDR_W-1:0] rd_data,
  output logic [LOC_W-1:0]            rd_addr,
  output logic                        wr_en,
  output logic [LOC_W-1:0]            wr_addr,
  output logic [sdam_pkg::ADDR_W-1:0] wr_data,
  output sdam_pkg::rsp_item_t         result
);
  import sdam_pkg::*;

  localparam int CW = LOC_W + 5;
  localparam int SH = LOC_W + 4;
  localparam int PW = LOC_W + SH;
  // Rounded-up reciprocal of ten; its error stays below a sixteenth, so the
  // truncated product is the exact quotient for every location value.
  localparam int RECIP = (2 ** SH + DECIMAL_BASE - 1) / DECIMAL_BASE;

  logic [LOC_W-1:0]    location_number;
  logic [LOC_W-1:0]    location_number_next;
  logic [STATUS_W-1:0] status_before;
  logic [STATUS_W-1:0] status_before_next;
  logic [CW-1:0]       cand;
  logic [PW-1:0]       prod;
  logic [LOC_W-1:0]    quot;
  logic                loc_ok;
  logic [LOC_W+SHOW_W-1:0] loc_wide;
  logic                write_req;

  always_comb begin
    cand   = CW'(DECIMAL_BASE) * CW'(location_number) + CW'(item.digit);
    prod   = PW'(location_number) * PW'(RECIP);
    quot   = prod[SH +: LOC_W];
    loc_ok = (location_number != '0) && (location_number <= LOC_W'(TABLE_ENTRIES));
  end

  always_comb begin
    location_number_next = location_number;
    status_before_next   = status_before;
    write_req            = 1'b0;
    result               = '0;
    result.new_status    = item.caller_status;
    result.error_code    = ERR_NONE;
    case (item.req_type)
      REQ_START_SAVE, REQ_START_RECALL: begin
        location_number_next = '0;
        status_before_next   = item.caller_status;
        result.new_status    = (item.req_type == REQ_START_SAVE) ? ST_SAVING : ST_RECALLING;
        result.show_location = 1'b1;
      end
      REQ_CLEAR: begin
        location_number_next = '0;
        result.show_location = 1'b1;
      end
      REQ_DIGIT: begin
        if (cand <= CW'(TABLE_ENTRIES)) begin
          location_number_next = cand[LOC_W-1:0];
        end else begin
          result.error_code = ERR_OVERFLOW;
        end
        result.show_location = 1'b1;
      end
      REQ_BACKSPACE: begin
        if (location_number != '0) begin
          location_number_next = quot;
        end else begin
          result.error_code = ERR_UNDERFLOW;
        end
        result.show_location = 1'b1;
      end
      REQ_ENTER_SAVE: begin
        if (loc_ok) begin
          write_req            = 1'b1;
          result.new_status    = status_before;
          result.address_value = item.calling_ip;
          result.show_address  = 1'b1;
        end else begin
          result.error_code = ERR_BAD_LOC;
        end
      end
      REQ_ENTER_RECALL: begin
        if (loc_ok) begin
          result.address_value = rd_data;
          result.show_address  = 1'b1;
          result.load_address  = 1'b1;
          result.new_status    = (status_before != ST_OFFHOOK) ? ST_RECALLED : ST_OFFHOOK;
        end else begin
          result.error_code = ERR_BAD_LOC;
        end
      end
      default: begin
      end
    endcase
    loc_wide = (LOC_W + SHOW_W)'(location_number_next);
    if (result.show_location) begin
      result.shown_location = loc_wide[SHOW_W-1:0];
    end
  end

  // The table is read ahead at the location the next item will see.
  always_comb begin
    rd_addr = fire ? location_number_next : location_number;
    wr_en   = fire & write_req;
    wr_addr = location_number;
    wr_data = item.calling_ip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      location_number <= '0;
      status_before   <= ST_OFFHOOK;
    end else if (fire) begin
      location_number <= location_number_next;
      status_before   <= status_before_next;
    end
  end

endmodule

/* src/speed_dial_address_memory_unit.sv */
// An item is held in the input register until it fires; its result is then
// registered. Throughput: one item per cycle while rsp.ready holds, set by
// the single pass of keypad logic between the input and result registers
// and the one-ahead table read. Reset: location number and saved status
// clear at once; the address table is then swept to zero, during which no
// item is accepted.
`include "speed_dial_address_memory_unit_macros.svh"

module speed_dial_address_memory_unit #(
  parameter int TABLE_ENTRIES = sdam_pkg::TABLE_ENTRIES_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  sdam_req_if.sink  req,
  sdam_rsp_if.source rsp
);
  import sdam_pkg::*;

  localparam int LOC_W = $clog2(TABLE_ENTRIES + 1);

  logic              in_vld;
  req_item_t         in_item;
  logic              rsp_vld;
  rsp_item_t         rsp_item;
  rsp_item_t         result;
  logic              adv;
  logic              fire;
  logic              busy;
  logic [LOC_W-1:0]  rd_addr;
  logic [ADDR_W-1:0] rd_data;
  logic              wr_en;
  logic [LOC_W-1:0]  wr_addr;
  logic [ADDR_W-1:0] wr_data;

  assign adv       = !rsp_vld || rsp.ready;
  assign fire      = in_vld && adv;
  assign req.ready = !busy && (!in_vld || adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.req_type      <= req.req_type;
      in_item.digit         <= req.digit;
      in_item.caller_status <= req.caller_status;
      in_item.calling_ip    <= req.calling_ip;
    end
  end

  sdam_keypad #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_keypad (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .item    (in_item),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .result  (result)
  );

  sdam_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (fire) begin
      rsp_vld <= 1'b1;
    end else if (rsp.ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_item <= result;
    end
  end

  assign rsp.valid          = rsp_vld;
  assign rsp.new_status     = rsp_item.new_status;
  assign rsp.shown_location = rsp_item.shown_location;
  assign rsp.show_location  = rsp_item.show_location;
  assign rsp.address_value  = rsp_item.address_value;
  assign rsp.show_address   = rsp_item.show_address;
  assign rsp.load_address   = rsp_item.load_address;
  assign rsp.error_code     = rsp_item.error_code;

  `SDAM_ASSERT_SAME(a_no_accept_while_clearing, busy, !(req.valid && req.ready))
  `SDAM_ASSERT_SAME(a_load_is_clean_recall, rsp.valid && rsp.load_address,
    rsp.show_address && (rsp.error_code == ERR_NONE) && !rsp.show_location)
  `SDAM_ASSERT_SAME(a_location_in_table, !busy, rd_addr <= LOC_W'(TABLE_ENTRIES))
  `SDAM_ASSERT_NEXT(a_held_item_kept, in_vld && !adv, in_vld && $stable(in_item))

endmodule
